### rtl/ppdf_pkg.sv
// Shared constants and types for the parallel port dual FIFO bridge.
`default_nettype none

package ppdf_pkg;

  // FIFO depths.
  localparam int RX_DEPTH = 128;
  localparam int TX_DEPTH = 256;

  // Slot address widths.
  localparam int RX_AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;

  // Pointers run modulo twice the depth.
  localparam int RX_PW = $clog2(2 * RX_DEPTH);
  localparam int TX_PW = $clog2(2 * TX_DEPTH);

  // Level width, one bit more than the pointer.
  localparam int RX_LW = RX_PW + 1;
  localparam int TX_LW = TX_PW + 1;

  // Event codes.
  typedef enum logic [2:0] {
    OP_HOST_IN   = 3'd0,
    OP_RD_LOW    = 3'd1,
    OP_RD_HIGH   = 3'd2,
    OP_WR_STROBE = 3'd3,
    OP_DRAIN     = 3'd4
  } op_t;

endpackage

`default_nettype wire

### rtl/parallel_port_dual_fifo.sv
// Top level of the parallel port dual FIFO bridge.
//
// The input channel carries one event per request: a host byte into the
// receive FIFO, a read strobe low or high, a write strobe into the transmit
// FIFO, or a host drain of the transmit FIFO. Every request yields exactly
// one result request on the output channel, carrying the bus byte, the bus
// drive state, the RXF and TXE lines, the drained byte and the accept flag.
// Both FIFOs live in synchronous RAMs with registered read data.
// A request is accepted, its RAM access and pointer update happen at that
// edge, and the result is registered in the following cycle from the RAM
// read data. No new request is taken while one is pending; the next request
// can be taken in the cycle after the result is loaded unless the receiver
// stalls, so the block never takes a request before the last one is through.
// While the receiver stalls, the result register holds and no further
// request is accepted.
// Reset clears both FIFOs to empty, raises RXF, lowers TXE and releases
// the bus; RAM contents are undefined until written.
`default_nettype none

module parallel_port_dual_fifo (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [2:0] in_operation,
  input  wire logic [7:0] in_host_data,
  input  wire logic [7:0] in_write_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_read_data,
  output logic            out_bus_driven,
  output logic            out_rx_empty_flag,
  output logic            out_tx_full_flag,
  output logic [7:0]      out_host_out_byte,
  output logic            out_host_out_valid,
  output logic            out_accepted
);

  import ppdf_pkg::*;

  // Pointer and line state.
  logic [RX_PW-1:0] rx_wp_r, rx_wp_nxt, rx_rp_r, rx_rp_nxt;
  logic [TX_PW-1:0] tx_wp_r, tx_wp_nxt, tx_rp_r, tx_rp_nxt;
  logic             rx_empty_line_r, rx_empty_line_nxt;
  logic             tx_full_line_r, tx_full_line_nxt;
  logic             bus_drive_r, bus_drive_nxt;

  // Pending request bookkeeping.
  logic pend_r, pend_nxt;
  logic pend_rd_r, pend_rd_nxt;
  logic pend_drain_r, pend_drain_nxt;
  logic pend_acc_r, pend_acc_nxt;

  // Result register.
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_read_data_r, out_read_data_nxt;
  logic       out_bus_driven_r, out_bus_driven_nxt;
  logic       out_rx_empty_r, out_rx_empty_nxt;
  logic       out_tx_full_r, out_tx_full_nxt;
  logic [7:0] out_host_byte_r, out_host_byte_nxt;
  logic       out_host_valid_r, out_host_valid_nxt;
  logic       out_accepted_r, out_accepted_nxt;

  // RAM ports.
  logic             rx_we, rx_re, tx_we, tx_re;
  logic [RX_AW-1:0] rx_waddr, rx_raddr;
  logic [TX_AW-1:0] tx_waddr, tx_raddr;
  logic [7:0]       rx_rdata, tx_rdata;

  // Levels and status.
  logic [RX_LW-1:0] rx_lvl;
  logic [TX_LW-1:0] tx_lvl;
  logic             rx_empty, rx_full, tx_empty, tx_full, tx_last_slot;
  logic             in_acc, out_take;

  // Handshakes.
  assign out_take = out_valid_r & ~out_stall;
  assign in_stall = pend_r | (out_valid_r & out_stall);
  assign in_acc   = in_valid & ~in_stall;

  // FIFO levels from the pointer difference modulo twice the depth.
  always_comb begin
    if (rx_wp_r >= rx_rp_r) begin
      rx_lvl = {1'b0, rx_wp_r} - {1'b0, rx_rp_r};
    end else begin
      rx_lvl = {1'b0, rx_wp_r} + RX_LW'(2 * RX_DEPTH) - {1'b0, rx_rp_r};
    end
    if (tx_wp_r >= tx_rp_r) begin
      tx_lvl = {1'b0, tx_wp_r} - {1'b0, tx_rp_r};
    end else begin
      tx_lvl = {1'b0, tx_wp_r} + TX_LW'(2 * TX_DEPTH) - {1'b0, tx_rp_r};
    end
  end

  assign rx_empty     = (rx_wp_r == rx_rp_r);
  assign tx_empty     = (tx_wp_r == tx_rp_r);
  assign rx_full      = (rx_lvl == RX_LW'(RX_DEPTH));
  assign tx_full      = (tx_lvl == TX_LW'(TX_DEPTH));
  assign tx_last_slot = (tx_lvl == TX_LW'(TX_DEPTH - 1));

  // Slot addresses fold the pointer back into the depth.
  always_comb begin
    rx_waddr = (rx_wp_r >= RX_PW'(RX_DEPTH)) ? RX_AW'(rx_wp_r - RX_PW'(RX_DEPTH))
                                              : RX_AW'(rx_wp_r);
    rx_raddr = (rx_rp_r >= RX_PW'(RX_DEPTH)) ? RX_AW'(rx_rp_r - RX_PW'(RX_DEPTH))
                                              : RX_AW'(rx_rp_r);
    tx_waddr = (tx_wp_r >= TX_PW'(TX_DEPTH)) ? TX_AW'(tx_wp_r - TX_PW'(TX_DEPTH))
                                              : TX_AW'(tx_wp_r);
    tx_raddr = (tx_rp_r >= TX_PW'(TX_DEPTH)) ? TX_AW'(tx_rp_r - TX_PW'(TX_DEPTH))
                                              : TX_AW'(tx_rp_r);
  end

  // Event decode: RAM accesses, pointer and line updates at acceptance.
  always_comb begin
    rx_wp_nxt         = rx_wp_r;
    rx_rp_nxt         = rx_rp_r;
    tx_wp_nxt         = tx_wp_r;
    tx_rp_nxt         = tx_rp_r;
    rx_empty_line_nxt = rx_empty_line_r;
    tx_full_line_nxt  = tx_full_line_r;
    bus_drive_nxt     = bus_drive_r;
    rx_we             = 1'b0;
    rx_re             = 1'b0;
    tx_we             = 1'b0;
    tx_re             = 1'b0;
    pend_nxt          = 1'b0;
    pend_rd_nxt       = pend_rd_r;
    pend_drain_nxt    = pend_drain_r;
    pend_acc_nxt      = pend_acc_r;
    if (in_acc) begin
      pend_nxt       = 1'b1;
      pend_rd_nxt    = 1'b0;
      pend_drain_nxt = 1'b0;
      pend_acc_nxt   = 1'b1;
      case (in_operation)
        OP_HOST_IN: begin
          if (!rx_full) begin
            rx_we             = 1'b1;
            rx_wp_nxt         = (rx_wp_r == RX_PW'(2 * RX_DEPTH - 1)) ? '0 : rx_wp_r + 1'b1;
            rx_empty_line_nxt = 1'b0;
          end else begin
            pend_acc_nxt = 1'b0;
          end
        end
        OP_RD_LOW: begin
          rx_re         = 1'b1;
          pend_rd_nxt   = 1'b1;
          bus_drive_nxt = 1'b1;
          if (!rx_empty) begin
            rx_rp_nxt = (rx_rp_r == RX_PW'(2 * RX_DEPTH - 1)) ? '0 : rx_rp_r + 1'b1;
          end
        end
        OP_RD_HIGH: begin
          bus_drive_nxt = 1'b0;
          if (rx_empty) begin
            rx_empty_line_nxt = 1'b1;
          end
        end
        OP_WR_STROBE: begin
          if (!tx_full) begin
            tx_we     = 1'b1;
            tx_wp_nxt = (tx_wp_r == TX_PW'(2 * TX_DEPTH - 1)) ? '0 : tx_wp_r + 1'b1;
            if (tx_last_slot) begin
              tx_full_line_nxt = 1'b1;
            end
          end else begin
            pend_acc_nxt     = 1'b0;
            tx_full_line_nxt = 1'b1;
          end
        end
        OP_DRAIN: begin
          if (!tx_empty) begin
            tx_re            = 1'b1;
            pend_drain_nxt   = 1'b1;
            tx_rp_nxt        = (tx_rp_r == TX_PW'(2 * TX_DEPTH - 1)) ? '0 : tx_rp_r + 1'b1;
            tx_full_line_nxt = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result assembly once the RAM data has arrived.
  always_comb begin
    out_valid_nxt      = out_valid_r & ~out_take;
    out_read_data_nxt  = out_read_data_r;
    out_bus_driven_nxt = out_bus_driven_r;
    out_rx_empty_nxt   = out_rx_empty_r;
    out_tx_full_nxt    = out_tx_full_r;
    out_host_byte_nxt  = out_host_byte_r;
    out_host_valid_nxt = out_host_valid_r;
    out_accepted_nxt   = out_accepted_r;
    if (pend_r) begin
      out_valid_nxt      = 1'b1;
      out_read_data_nxt  = pend_rd_r ? rx_rdata : 8'd0;
      out_bus_driven_nxt = bus_drive_r;
      out_rx_empty_nxt   = rx_empty_line_r;
      out_tx_full_nxt    = tx_full_line_r;
      out_host_byte_nxt  = pend_drain_r ? tx_rdata : 8'd0;
      out_host_valid_nxt = pend_drain_r;
      out_accepted_nxt   = pend_acc_r;
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_wp_r         <= '0;
      rx_rp_r         <= '0;
      tx_wp_r         <= '0;
      tx_rp_r         <= '0;
      rx_empty_line_r <= 1'b1;
      tx_full_line_r  <= 1'b0;
      bus_drive_r     <= 1'b0;
      pend_r          <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      rx_wp_r         <= rx_wp_nxt;
      rx_rp_r         <= rx_rp_nxt;
      tx_wp_r         <= tx_wp_nxt;
      tx_rp_r         <= tx_rp_nxt;
      rx_empty_line_r <= rx_empty_line_nxt;
      tx_full_line_r  <= tx_full_line_nxt;
      bus_drive_r     <= bus_drive_nxt;
      pend_r          <= pend_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pend_rd_r        <= pend_rd_nxt;
    pend_drain_r     <= pend_drain_nxt;
    pend_acc_r       <= pend_acc_nxt;
    out_read_data_r  <= out_read_data_nxt;
    out_bus_driven_r <= out_bus_driven_nxt;
    out_rx_empty_r   <= out_rx_empty_nxt;
    out_tx_full_r    <= out_tx_full_nxt;
    out_host_byte_r  <= out_host_byte_nxt;
    out_host_valid_r <= out_host_valid_nxt;
    out_accepted_r   <= out_accepted_nxt;
  end

  // Receive FIFO storage.
  ppdf_ram #(
    .DEPTH (RX_DEPTH),
    .WIDTH (8)
  ) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_waddr),
    .wdata (in_host_data),
    .re    (rx_re),
    .raddr (rx_raddr),
    .rdata (rx_rdata)
  );

  // Transmit FIFO storage.
  ppdf_ram #(
    .DEPTH (TX_DEPTH),
    .WIDTH (8)
  ) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_waddr),
    .wdata (in_write_data),
    .re    (tx_re),
    .raddr (tx_raddr),
    .rdata (tx_rdata)
  );

  // Output ports.
  assign out_valid          = out_valid_r;
  assign out_read_data      = out_read_data_r;
  assign out_bus_driven     = out_bus_driven_r;
  assign out_rx_empty_flag  = out_rx_empty_r;
  assign out_tx_full_flag   = out_tx_full_r;
  assign out_host_out_byte  = out_host_byte_r;
  assign out_host_out_valid = out_host_valid_r;
  assign out_accepted       = out_accepted_r;

  // Every accepted request is followed by a result on the output.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> ##1 out_valid_r)
    else $error("result not offered two cycles after acceptance");

  // The receive level never exceeds the depth.
  a_rx_level: assert property (@(posedge clk) disable iff (!rst_n)
    rx_lvl <= RX_LW'(RX_DEPTH))
    else $error("receive FIFO level beyond depth");

  // TXE high only while the transmit FIFO is full.
  a_txe_full: assert property (@(posedge clk) disable iff (!rst_n)
    tx_full_line_r |-> tx_full)
    else $error("TXE line high with room in transmit FIFO");

  // RXF high only while the receive FIFO is empty.
  a_rxf_empty: assert property (@(posedge clk) disable iff (!rst_n)
    rx_empty_line_r |-> rx_empty)
    else $error("RXF line high with data in receive FIFO");

endmodule

`default_nettype wire

### rtl/ppdf_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
`default_nettype none

module ppdf_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered read data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### sim/parallel_port_dual_fifo_tb.sv
// Self-checking testbench for the parallel port dual FIFO bridge.
`timescale 1ns / 1ps

module parallel_port_dual_fifo_tb;
  import ppdf_pkg::*;

  // Codes the 3-bit event field can carry beyond the defined events.
  localparam logic [2:0] OP_UNUSED_LO = 3'(OP_DRAIN + 1);
  localparam logic [2:0] OP_UNUSED_HI = 3'b111;

  // Stimulus size and tail length.
  localparam int ITEM_TARGET = 1650;
  localparam int TAIL_CYCLES = 8;

  // Kinds of stimulus phases.
  typedef enum int {
    PH_MIX,
    PH_RX_FILL,
    PH_RX_READ,
    PH_TX_FILL,
    PH_TX_DRAIN
  } phase_t;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] host_data;
    logic [7:0] write_data;
  } bridge_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       bus_driven;
    logic       rx_empty;
    logic       tx_full;
    logic [7:0] host_byte;
    logic       host_valid;
    logic       accepted;
  } bridge_res_t;

  // Tracks both FIFOs and the bus lines, and holds the results still due.
  class bridge_tracker;
    logic [7:0]       rx_mem [RX_DEPTH];
    bit               rx_seen [RX_DEPTH];
    logic [7:0]       tx_mem [TX_DEPTH];
    logic [RX_PW-1:0] rx_wr_ptr, rx_rd_ptr;
    logic [TX_PW-1:0] tx_wr_ptr, tx_rd_ptr;
    logic             rxf_line, txe_line, bus_on;
    bridge_res_t      due_q[$];
    int               faults, checked;
    int               op_count [8];
    int               rx_drops, tx_drops, stale_reads, empty_drains;

    function new();
      rx_wr_ptr = '0;
      rx_rd_ptr = '0;
      tx_wr_ptr = '0;
      tx_rd_ptr = '0;
      rxf_line = 1'b1;
      txe_line = 1'b0;
      bus_on = 1'b0;
      foreach (rx_seen[i]) rx_seen[i] = 1'b0;
    endfunction

    function int bump(int p, int depth);
      return (p + 1 >= 2 * depth) ? 0 : p + 1;
    endfunction

    function int fill(int wp, int rp, int depth);
      return (wp >= rp) ? wp - rp : wp + 2 * depth - rp;
    endfunction

    function int slot(int p, int depth);
      return (p >= depth) ? p - depth : p;
    endfunction

    function int rx_level();
      return fill(rx_wr_ptr, rx_rd_ptr, RX_DEPTH);
    endfunction

    function int tx_level();
      return fill(tx_wr_ptr, tx_rd_ptr, TX_DEPTH);
    endfunction

    // A read of an empty receive FIFO must land on a slot that holds data.
    function bit stale_slot_unwritten();
      return rx_level() == 0 && !rx_seen[slot(rx_rd_ptr, RX_DEPTH)];
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    // Apply one accepted request and queue the result it must produce.
    function void note_request(bridge_req_t r);
      bridge_res_t want;
      int          rx_lvl, tx_lvl;
      want = '0;
      want.accepted = 1'b1;
      rx_lvl = rx_level();
      tx_lvl = tx_level();
      op_count[r.op]++;
      case (r.op)
        OP_HOST_IN: begin
          if (rx_lvl < RX_DEPTH) begin
            rx_mem[slot(rx_wr_ptr, RX_DEPTH)] = r.host_data;
            rx_seen[slot(rx_wr_ptr, RX_DEPTH)] = 1'b1;
            rx_wr_ptr = RX_PW'(bump(rx_wr_ptr, RX_DEPTH));
            rxf_line = 1'b0;
          end else begin
            want.accepted = 1'b0;
            rx_drops++;
          end
        end
        OP_RD_LOW: begin
          want.read_data = rx_mem[slot(rx_rd_ptr, RX_DEPTH)];
          if (rx_lvl != 0) rx_rd_ptr = RX_PW'(bump(rx_rd_ptr, RX_DEPTH));
          else stale_reads++;
          bus_on = 1'b1;
        end
        OP_RD_HIGH: begin
          bus_on = 1'b0;
          if (rx_lvl == 0) rxf_line = 1'b1;
        end
        OP_WR_STROBE: begin
          if (tx_lvl < TX_DEPTH) begin
            tx_mem[slot(tx_wr_ptr, TX_DEPTH)] = r.write_data;
            tx_wr_ptr = TX_PW'(bump(tx_wr_ptr, TX_DEPTH));
            if (tx_lvl + 1 == TX_DEPTH) txe_line = 1'b1;
          end else begin
            want.accepted = 1'b0;
            txe_line = 1'b1;
            tx_drops++;
          end
        end
        OP_DRAIN: begin
          if (tx_lvl != 0) begin
            want.host_byte = tx_mem[slot(tx_rd_ptr, TX_DEPTH)];
            want.host_valid = 1'b1;
            tx_rd_ptr = TX_PW'(bump(tx_rd_ptr, TX_DEPTH));
            txe_line = 1'b0;
          end else begin
            empty_drains++;
          end
        end
        default: ;
      endcase
      want.bus_driven = bus_on;
      want.rx_empty = rxf_line;
      want.tx_full = txe_line;
      due_q.push_back(want);
    endfunction

    task log_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      faults++;
    endtask

    // Compare one accepted result with the oldest one due.
    task check_result(bridge_res_t got);
      bridge_res_t want;
      if (due_q.size() == 0) begin
        log_mismatch($sformatf("result with none due: %h", got));
        return;
      end
      want = due_q.pop_front();
      checked++;
      if (got !== want)
        log_mismatch($sformatf(
          "result %0d rd/bus/rxf/txe/hb/hv/acc want %h %b %b %b %h %b %b got %h %b %b %b %h %b %b",
          checked, want.read_data, want.bus_driven, want.rx_empty, want.tx_full,
          want.host_byte, want.host_valid, want.accepted, got.read_data, got.bus_driven,
          got.rx_empty, got.tx_full, got.host_byte, got.host_valid, got.accepted));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] in_operation = '0;
  logic [7:0] in_host_data = '0;
  logic [7:0] in_write_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_read_data;
  logic       out_bus_driven;
  logic       out_rx_empty_flag;
  logic       out_tx_full_flag;
  logic [7:0] out_host_out_byte;
  logic       out_host_out_valid;
  logic       out_accepted;

  bridge_tracker sb;
  int            in_idle = 0;
  int            out_idle = 0;
  int            stall_left = 0;
  int            live_items = 0;

  parallel_port_dual_fifo u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_host_data      (in_host_data),
    .in_write_data     (in_write_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_read_data     (out_read_data),
    .out_bus_driven    (out_bus_driven),
    .out_rx_empty_flag (out_rx_empty_flag),
    .out_tx_full_flag  (out_tx_full_flag),
    .out_host_out_byte (out_host_out_byte),
    .out_host_out_valid(out_host_out_valid),
    .out_accepted      (out_accepted)
  );

  // 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Idle length for one slot: zero in quiet phases, else mostly short.
  function automatic int pick_gap(int mode);
    int roll;
    if (mode == 0) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Receiver stalls in random bursts.
  always @(negedge clk) begin
    int gap;
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      gap = pick_gap(out_idle);
      out_stall <= (gap > 0);
      stall_left <= (gap > 0) ? gap - 1 : 0;
    end
  end

  // Every accepted result is checked against the oldest one due.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result('{out_read_data, out_bus_driven, out_rx_empty_flag, out_tx_full_flag,
                        out_host_out_byte, out_host_out_valid, out_accepted});
  end

  // Build a request, keeping reads of empty FIFOs on slots that hold data.
  function automatic bridge_req_t make_req(logic [2:0] op, logic [7:0] hd, logic [7:0] wd);
    bridge_req_t r;
    r.op = op;
    r.host_data = hd;
    r.write_data = wd;
    if (r.op == OP_RD_LOW && sb.stale_slot_unwritten()) r.op = OP_HOST_IN;
    return r;
  endfunction

  // Offer one request at the falling edge and hold it until accepted.
  task automatic send_request(bridge_req_t r);
    int gap;
    gap = pick_gap(in_idle);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= r.op;
    in_host_data <= r.host_data;
    in_write_data <= r.write_data;
    do @(posedge clk); while (in_stall);
    sb.note_request(r);
    if (r.op <= OP_DRAIN) live_items++;
    @(negedge clk);
  endtask

  task automatic send_op(logic [2:0] op, logic [7:0] hd, logic [7:0] wd);
    send_request(make_req(op, hd, wd));
  endtask

  // Pick the next event for a phase; n is its position within the phase.
  function automatic logic [2:0] phase_op(phase_t kind, int n);
    int roll;
    roll = $urandom_range(0, 99);
    case (kind)
      PH_RX_FILL:  return (roll < 95) ? 3'(OP_HOST_IN) : 3'(OP_WR_STROBE);
      PH_TX_FILL:  return (roll < 95) ? 3'(OP_WR_STROBE) : 3'(OP_HOST_IN);
      PH_TX_DRAIN: return (roll < 95) ? 3'(OP_DRAIN) : 3'(OP_RD_HIGH);
      PH_RX_READ: begin
        // Strobe pairs, low then high, with some broken pairs.
        if (roll < 10) return (roll < 5) ? 3'(OP_RD_LOW) : 3'(OP_RD_HIGH);
        return (n % 2 == 0) ? 3'(OP_RD_LOW) : 3'(OP_RD_HIGH);
      end
      default: begin
        if (roll < 90) return 3'($urandom_range(OP_HOST_IN, OP_DRAIN));
        return 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      end
    endcase
  endfunction

  task automatic run_phase(phase_t kind);
    int budget;
    case (kind)
      PH_RX_FILL:  budget = RX_DEPTH - sb.rx_level() + $urandom_range(2, 8);
      PH_TX_FILL:  budget = TX_DEPTH - sb.tx_level() + $urandom_range(2, 8);
      PH_TX_DRAIN: budget = sb.tx_level() + $urandom_range(1, 4);
      PH_RX_READ:  budget = 2 * (sb.rx_level() + $urandom_range(1, 3));
      default:     budget = $urandom_range(20, 80);
    endcase
    for (int n = 0; n < budget; n++)
      send_op(phase_op(kind, n), 8'($urandom), 8'($urandom));
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty FIFOs, unused codes, byte extremes, strobes and drains.
    in_idle = 1;
    out_idle = 1;
    send_op(OP_RD_HIGH, 8'h00, 8'h00);
    send_op(OP_DRAIN, 8'h00, 8'h00);
    send_op(OP_UNUSED_LO, 8'hFF, 8'hFF);
    send_op(OP_UNUSED_HI, 8'hFF, 8'hFF);
    send_op(OP_HOST_IN, 8'h00, 8'hFF);
    send_op(OP_HOST_IN, 8'hFF, 8'h00);
    send_op(OP_RD_LOW, 8'h00, 8'h00);
    send_op(OP_RD_HIGH, 8'h00, 8'h00);
    send_op(OP_RD_LOW, 8'h00, 8'h00);
    send_op(OP_RD_LOW, 8'h00, 8'h00);
    send_op(OP_RD_HIGH, 8'h00, 8'h00);
    send_op(OP_WR_STROBE, 8'hFF, 8'h00);
    send_op(OP_WR_STROBE, 8'h00, 8'hFF);
    send_op(OP_WR_STROBE, 8'h00, 8'hA5);
    send_op(OP_DRAIN, 8'h00, 8'h00);
    send_op(OP_DRAIN, 8'h00, 8'h00);
    send_op(OP_DRAIN, 8'h00, 8'h00);
    send_op(OP_DRAIN, 8'h00, 8'h00);
    send_op(OP_RD_HIGH, 8'h00, 8'h00);

    // Random phases: fills past full, drains past empty, and mixed traffic.
    while (live_items < ITEM_TARGET) begin
      in_idle = $urandom_range(0, 2);
      out_idle = $urandom_range(0, 2);
      run_phase(phase_t'($urandom_range(PH_MIX, PH_TX_DRAIN)));
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent host-in %0d, read-low %0d, read-high %0d, write %0d, drain %0d, unused %0d.",
             sb.op_count[OP_HOST_IN], sb.op_count[OP_RD_LOW], sb.op_count[OP_RD_HIGH],
             sb.op_count[OP_WR_STROBE], sb.op_count[OP_DRAIN],
             sb.op_count[5] + sb.op_count[6] + sb.op_count[7]);
    $display("Checked %0d results: %0d rx drops, %0d tx drops, %0d stale reads, %0d empty drains.",
             sb.checked, sb.rx_drops, sb.tx_drops, sb.stale_reads, sb.empty_drains);
    if (sb.faults == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule

### sim.f
rtl/ppdf_pkg.sv
rtl/ppdf_ram.sv
rtl/parallel_port_dual_fifo.sv
sim/parallel_port_dual_fifo_tb.sv
